// ===== sv/vas_pkg.sv =====
// Shared types, codes and helpers for the voice allocator.
// Used by vas_mem, vas_ctrl and voice_allocator_with_stealing_top; no dependencies.
package vas_pkg;

	localparam int NUM_SLOTS_DEF = 32;

	// command codes
	localparam logic [2:0] CMD_NOTE_ON  = 3'd0;
	localparam logic [2:0] CMD_NOTE_OFF = 3'd1;
	localparam logic [2:0] CMD_REL_PEND = 3'd2;
	localparam logic [2:0] CMD_ALL_OFF  = 3'd3;
	localparam logic [2:0] CMD_LEVEL    = 3'd4;
	localparam logic [2:0] CMD_DONE     = 3'd5;

	// result action codes
	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_START   = 3'd1;
	localparam logic [2:0] ACT_DAMP    = 3'd2;
	localparam logic [2:0] ACT_RELEASE = 3'd3;
	localparam logic [2:0] ACT_PENDING = 3'd4;

	// configuration register indexes
	localparam logic CFG_POOL  = 1'b0;
	localparam logic CFG_PEDAL = 1'b1;

	localparam logic [5:0]  POOL_RESET  = 6'd32;
	localparam logic [15:0] LEVEL_FRESH = 16'hFFFF;

	// one voice slot as stored in the slot table
	typedef struct packed {
		logic        active;
		logic        releasing;
		logic        pending;
		logic [6:0]  note;
		logic [15:0] level;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_STEAL,
		ST_START,
		ST_FLUSH,
		ST_ONE_RD,
		ST_ONE_WR
	} state_t;

	// clamp a pool_in_use value to 1..size
	function automatic logic [6:0] clamp_pool(input logic [5:0] v, input logic [6:0] size);
		logic [6:0] r;
		r = {1'b0, v};
		if (r == 7'd0) r = 7'd1;
		if (r > size) r = size;
		return r;
	endfunction

endpackage

// ===== sv/vas_mem.sv =====
// Slot table: one synchronous memory, one write and one read port, registered read.
// Per-entry valid bits give reset-to-zero and pool shrink clearing. Depends on vas_pkg.
module vas_mem #(
	parameter int DEPTH = vas_pkg::NUM_SLOTS_DEF,
	parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           we,
	input  logic [IW-1:0]  waddr,
	input  vas_pkg::entry_t wdata,
	input  logic [IW-1:0]  raddr,
	output vas_pkg::entry_t rdata,
	input  logic           clr,
	input  logic [CW-1:0]  clr_from
);

	vas_pkg::entry_t mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	vas_pkg::entry_t rdata_q;

	// storage array, no reset
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// registered read; an entry never written since reset or shrink reads as zero
	always_ff @(posedge clk) begin
		rdata_q <= valid_q[raddr] ? mem[raddr] : '0;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < DEPTH; i++) begin
				if (clr && (CW'(i) >= clr_from)) valid_q[i] <= 1'b0;
			end
			if (we) valid_q[waddr] <= 1'b1;
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/vas_ctrl.sv =====
// Command sequencer: scans the slot table one entry per cycle, tracks steal candidates,
// issues read-modify-write beats and emits results. Depends on vas_pkg.
module vas_ctrl #(
	parameter int NUM_SLOTS = vas_pkg::NUM_SLOTS_DEF,
	parameter int IW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
	parameter int CW        = $clog2(NUM_SLOTS + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic [2:0]      cmd,
	input  logic [6:0]      note,
	input  logic            sustained,
	input  logic [4:0]      slot,
	input  logic [15:0]     level,
	input  logic            cfg_we,
	input  logic            cfg_idx,
	input  logic [5:0]      cfg_wdata,
	output logic            strobe,
	output logic [2:0]      action,
	output logic [4:0]      voice_slot,
	output logic [6:0]      voice_note,
	output logic            last,
	output logic            mem_we,
	output logic [IW-1:0]   mem_waddr,
	output vas_pkg::entry_t mem_wdata,
	output logic [IW-1:0]   mem_raddr,
	input  vas_pkg::entry_t mem_rdata,
	output logic            mem_clr,
	output logic [CW-1:0]   mem_clr_from
);

	localparam logic [6:0] SIZE7 = 7'(NUM_SLOTS);

	vas_pkg::state_t state_q, state_d;

	// configuration
	logic [5:0] pool_q;
	logic       pedal_q;
	logic [CW-1:0] n_c;

	// latched command
	logic [2:0]  cmd_q;
	logic [6:0]  note_q;
	logic        sus_q;
	logic [4:0]  slot_q;
	logic [15:0] level_q;

	// scan pipeline
	logic [CW-1:0] rd_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	// steal candidates
	logic          free_v_q, rel_v_q, pen_v_q;
	logic [IW-1:0] free_idx_q, rel_idx_q, pen_idx_q, all_idx_q;
	logic [15:0]   rel_lvl_q, pen_lvl_q, all_lvl_q;
	logic [6:0]    rel_note_q, pen_note_q, all_note_q;

	// held result of a release scan
	logic          hold_v_q;
	logic [2:0]    hold_act_q;
	logic [IW-1:0] hold_slot_q;
	logic [6:0]    hold_note_q;

	// result register
	logic       strobe_q, last_q;
	logic [2:0] action_q;
	logic [4:0] vslot_q;
	logic [6:0] vnote_q;

	logic          accept, scan_end, slot_in;
	logic          m_dmp, m_off, m_rel;
	logic          p_act, p_rel, p_pen;
	logic [15:0]   p_lvl;
	logic          emit_v, emit_last;
	logic [2:0]    emit_act;
	logic [IW-1:0] emit_slot;
	logic [6:0]    emit_note;
	logic [IW-1:0] sel_idx;
	logic [6:0]    sel_note;
	vas_pkg::entry_t d;

	assign n_c      = CW'(vas_pkg::clamp_pool(pool_q, SIZE7));
	assign busy     = (state_q != vas_pkg::ST_IDLE);
	assign accept   = start && !busy;
	assign d        = mem_rdata;
	assign scan_end = vld_s1 && ((CW'(idx_s1) + CW'(1)) == n_c);
	assign slot_in  = ({2'b00, slot} < vas_pkg::clamp_pool(pool_q, SIZE7));

	// per-entry match terms of the scan
	always_comb begin
		m_dmp = (cmd_q == vas_pkg::CMD_NOTE_ON) && d.active && (d.note == note_q);
		m_off = (cmd_q == vas_pkg::CMD_NOTE_OFF) && d.active && (d.note == note_q)
			&& !d.releasing;
		m_rel = ((cmd_q == vas_pkg::CMD_REL_PEND) && d.active && !d.releasing && d.pending)
			|| ((cmd_q == vas_pkg::CMD_ALL_OFF) && d.active && !d.releasing);
		p_act = d.active && !m_dmp;
		p_rel = d.releasing && !m_dmp;
		p_pen = d.pending && !m_dmp;
		p_lvl = m_dmp ? 16'd0 : d.level;
	end

	// slot picked for note-on
	always_comb begin
		if (free_v_q) begin
			sel_idx  = free_idx_q;
			sel_note = 7'd0;
		end else if (rel_v_q) begin
			sel_idx  = rel_idx_q;
			sel_note = rel_note_q;
		end else if (pedal_q && pen_v_q) begin
			sel_idx  = pen_idx_q;
			sel_note = pen_note_q;
		end else begin
			sel_idx  = all_idx_q;
			sel_note = all_note_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			vas_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd inside {vas_pkg::CMD_NOTE_ON, vas_pkg::CMD_NOTE_OFF,
						vas_pkg::CMD_REL_PEND, vas_pkg::CMD_ALL_OFF})
						state_d = vas_pkg::ST_SCAN;
					else if ((cmd inside {vas_pkg::CMD_LEVEL, vas_pkg::CMD_DONE}) && slot_in)
						state_d = vas_pkg::ST_ONE_RD;
				end
			end
			vas_pkg::ST_SCAN: begin
				if (scan_end)
					state_d = (cmd_q == vas_pkg::CMD_NOTE_ON) ? vas_pkg::ST_STEAL
						: vas_pkg::ST_FLUSH;
			end
			vas_pkg::ST_STEAL:  state_d = vas_pkg::ST_START;
			vas_pkg::ST_START:  state_d = vas_pkg::ST_IDLE;
			vas_pkg::ST_FLUSH:  state_d = vas_pkg::ST_IDLE;
			vas_pkg::ST_ONE_RD: state_d = vas_pkg::ST_ONE_WR;
			vas_pkg::ST_ONE_WR: state_d = vas_pkg::ST_IDLE;
			default:            state_d = vas_pkg::ST_IDLE;
		endcase
	end

	// memory beats and result emission
	always_comb begin
		mem_we       = 1'b0;
		mem_waddr    = idx_s1;
		mem_wdata    = d;
		mem_raddr    = rd_q[IW-1:0];
		emit_v       = 1'b0;
		emit_last    = 1'b0;
		emit_act     = vas_pkg::ACT_NONE;
		emit_slot    = idx_s1;
		emit_note    = note_q;
		mem_clr      = cfg_we && (cfg_idx == vas_pkg::CFG_POOL);
		mem_clr_from = CW'(vas_pkg::clamp_pool(cfg_wdata, SIZE7));
		case (state_q)
			vas_pkg::ST_SCAN: begin
				if (vld_s1) begin
					if (m_dmp) begin
						mem_we    = 1'b1;
						mem_wdata = '{active: 1'b0, releasing: 1'b0, pending: 1'b0,
							note: d.note, level: 16'd0};
						emit_v    = 1'b1;
						emit_act  = vas_pkg::ACT_DAMP;
					end else if (m_off || m_rel) begin
						mem_we = 1'b1;
						if (m_off && sus_q) begin
							mem_wdata.pending = 1'b1;
						end else begin
							mem_wdata.releasing = 1'b1;
							mem_wdata.pending   = 1'b0;
						end
						// the previous match goes out now that it is known not to be final
						emit_v    = hold_v_q;
						emit_act  = hold_act_q;
						emit_slot = hold_slot_q;
						emit_note = hold_note_q;
					end
				end
			end
			vas_pkg::ST_STEAL: begin
				emit_v    = !free_v_q;
				emit_act  = vas_pkg::ACT_DAMP;
				emit_slot = sel_idx;
				emit_note = sel_note;
			end
			vas_pkg::ST_START: begin
				mem_we    = 1'b1;
				mem_waddr = sel_idx;
				mem_wdata = '{active: 1'b1, releasing: 1'b0, pending: 1'b0,
					note: note_q, level: vas_pkg::LEVEL_FRESH};
				emit_v    = 1'b1;
				emit_last = 1'b1;
				emit_act  = vas_pkg::ACT_START;
				emit_slot = sel_idx;
			end
			vas_pkg::ST_FLUSH: begin
				emit_v    = hold_v_q;
				emit_last = 1'b1;
				emit_act  = hold_act_q;
				emit_slot = hold_slot_q;
				emit_note = hold_note_q;
			end
			vas_pkg::ST_ONE_RD: begin
				mem_raddr = IW'(slot_q);
			end
			vas_pkg::ST_ONE_WR: begin
				mem_we    = 1'b1;
				mem_waddr = IW'(slot_q);
				if (cmd_q == vas_pkg::CMD_LEVEL) begin
					mem_wdata.level = level_q;
				end else begin
					mem_wdata = '{active: 1'b0, releasing: 1'b0, pending: 1'b0,
						note: d.note, level: 16'd0};
				end
			end
			default: ;
		endcase
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= vas_pkg::ST_IDLE;
			pool_q   <= vas_pkg::POOL_RESET;
			pedal_q  <= 1'b1;
			vld_s1   <= 1'b0;
			hold_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit_v;
			if (cfg_we) begin
				if (cfg_idx == vas_pkg::CFG_POOL) pool_q <= cfg_wdata;
				else pedal_q <= cfg_wdata[0];
			end
			vld_s1 <= (state_q == vas_pkg::ST_SCAN) && (rd_q < n_c);
			if (accept) hold_v_q <= 1'b0;
			else if ((state_q == vas_pkg::ST_SCAN) && vld_s1 && (m_off || m_rel))
				hold_v_q <= 1'b1;
		end
	end

	// scan counters, candidates and payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			note_q   <= note;
			sus_q    <= sustained;
			slot_q   <= slot;
			level_q  <= level;
			rd_q     <= '0;
			free_v_q <= 1'b0;
			rel_v_q  <= 1'b0;
			pen_v_q  <= 1'b0;
		end else if (state_q == vas_pkg::ST_SCAN) begin
			if (rd_q < n_c) rd_q <= rd_q + CW'(1);
			if (vld_s1) begin
				if (!p_act && !free_v_q) begin
					free_v_q   <= 1'b1;
					free_idx_q <= idx_s1;
				end
				if (p_rel && (!rel_v_q || (p_lvl < rel_lvl_q))) begin
					rel_v_q    <= 1'b1;
					rel_idx_q  <= idx_s1;
					rel_lvl_q  <= p_lvl;
					rel_note_q <= d.note;
				end
				if (p_pen && (!pen_v_q || (p_lvl < pen_lvl_q))) begin
					pen_v_q    <= 1'b1;
					pen_idx_q  <= idx_s1;
					pen_lvl_q  <= p_lvl;
					pen_note_q <= d.note;
				end
				if ((idx_s1 == '0) || (p_lvl < all_lvl_q)) begin
					all_idx_q  <= idx_s1;
					all_lvl_q  <= p_lvl;
					all_note_q <= d.note;
				end
				if (m_off || m_rel) begin
					hold_act_q  <= (m_off && sus_q) ? vas_pkg::ACT_PENDING
						: vas_pkg::ACT_RELEASE;
					hold_slot_q <= idx_s1;
					hold_note_q <= d.note;
				end
			end
		end
		// index of the entry whose read data arrives next cycle
		idx_s1 <= rd_q[IW-1:0];
		action_q <= emit_act;
		vslot_q  <= 5'(emit_slot);
		vnote_q  <= emit_note;
		last_q   <= emit_last;
	end

	assign strobe     = strobe_q;
	assign action     = action_q;
	assign voice_slot = vslot_q;
	assign voice_note = vnote_q;
	assign last       = last_q;

`ifndef SYNTHESIS
	a_scan_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vas_pkg::ST_SCAN && vld_s1) |-> (CW'(idx_s1) < n_c))
		else $error("scan entry beyond pool");
	a_start_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_v && emit_act == vas_pkg::ACT_START) |-> emit_last)
		else $error("start beat not final");
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vas_pkg::ST_IDLE) |-> !mem_we)
		else $error("table write while idle");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_v && emit_last) |=> (state_q == vas_pkg::ST_IDLE))
		else $error("final beat while command still running");
`endif

endmodule

// ===== sv/voice_allocator_with_stealing_top.sv =====
// Voice allocator with stealing: a start/busy command port, a result strobe per beat.
// Throughput: one command at a time, set by the one-entry-per-cycle table scan.
// Results cannot be stalled by the receiver; one beat per strobe cycle.
// Reset: async active low; table reads as empty, pool_in_use=32, pedal_aware=1.
// Depends on vas_pkg, vas_mem, vas_ctrl.
module voice_allocator_with_stealing_top #(
	parameter int NUM_SLOTS = vas_pkg::NUM_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [6:0]  note,
	input  logic        sustained,
	input  logic [4:0]  slot,
	input  logic [15:0] level,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [5:0]  cfg_wdata,
	output logic        strobe,
	output logic [2:0]  action,
	output logic [4:0]  voice_slot,
	output logic [6:0]  voice_note,
	output logic        last
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);

	logic            mem_we, mem_clr;
	logic [IW-1:0]   mem_waddr, mem_raddr;
	logic [CW-1:0]   mem_clr_from;
	vas_pkg::entry_t mem_wdata, mem_rdata;

	vas_mem #(.DEPTH(NUM_SLOTS), .IW(IW), .CW(CW)) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (mem_we),
		.waddr    (mem_waddr),
		.wdata    (mem_wdata),
		.raddr    (mem_raddr),
		.rdata    (mem_rdata),
		.clr      (mem_clr),
		.clr_from (mem_clr_from)
	);

	vas_ctrl #(.NUM_SLOTS(NUM_SLOTS), .IW(IW), .CW(CW)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.note         (note),
		.sustained    (sustained),
		.slot         (slot),
		.level        (level),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.strobe       (strobe),
		.action       (action),
		.voice_slot   (voice_slot),
		.voice_note   (voice_note),
		.last         (last),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata),
		.mem_clr      (mem_clr),
		.mem_clr_from (mem_clr_from)
	);

endmodule
